FILE: src/assert_macros.svh
// Assertion macros used by the timer scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg)
`endif
`endif

FILE: src/pts_pkg.sv
// Types, codes and sizes of the periodic timer scheduler.
package pts_pkg;

   localparam int TIMER_SLOTS = 16;
   localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   localparam logic [31:0] DELAY_MAX = 32'h7FFF_FFFF;

   localparam logic [1:0] REQ_ARM_ONCE     = 2'd0;
   localparam logic [1:0] REQ_ARM_PERIODIC = 2'd1;
   localparam logic [1:0] REQ_TICK         = 2'd2;

   localparam logic [1:0] RES_DISPATCH  = 2'd0;
   localparam logic [1:0] RES_ARMED     = 2'd1;
   localparam logic [1:0] RES_DROPPED   = 2'd2;
   localparam logic [1:0] RES_IDLE_TICK = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] task_handle;
      logic [31:0] delay_ticks;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] out_handle;
      logic        is_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [31:0] expiry;
      logic [31:0] period;
      logic [15:0] task_id;
      logic [31:0] seq_num;
   } slot_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

endpackage

FILE: src/periodic_timer_scheduler.sv
// Periodic timer scheduler: timer table in one synchronous memory, scanned per tick.
//
// Requests arrive on the req_ channel (valid/stall), one transaction per request:
// arm one-shot, arm periodic, or one tick. Results leave on the rsp_ channel, one
// transaction per result; is_last marks the final result of a request.
// An arm request (or an unused code) yields one result, registered in the cycle
// after acceptance; the next request is taken once the output can accept a result.
// A tick advances the time counter, then scans the slot memory one entry per cycle
// for the earliest expired timer (ties by arm order), through the single read port
// of the slot memory; each timer found is dispatched and the table scanned again,
// and at most MAX_RESULTS timers leave per tick.
// Periodic timers are written back with a new expiry; one-shot timers are freed.
// Reset clears the time counter, the arm sequence and all slot valid bits; the
// block takes a request on the first cycle after reset.
// While rsp_stall is high the pending result holds and the block waits before
// producing another; req_stall stays high until the current request is finished.
`include "assert_macros.svh"

module periodic_timer_scheduler (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pts_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output pts_pkg::rsp_payload_type rsp_data
);
   import pts_pkg::*;

   state_type              state_ff, state_in;
   logic [31:0]            ct_ff, ct_in;
   logic [31:0]            ns_ff, ns_in;
   logic [TIMER_SLOTS-1:0] valid_ff, valid_in;
   logic [SLOT_W:0]        scan_cnt_ff, scan_cnt_in;
   logic                   found_ff, found_in;
   logic [SLOT_W-1:0]      best_idx_ff, best_idx_in;
   logic [31:0]            best_age_ff, best_age_in;
   logic [31:0]            best_sage_ff, best_sage_in;
   logic [31:0]            best_period_ff, best_period_in;
   logic [15:0]            best_task_ff, best_task_in;
   logic                   pend_valid_ff, pend_valid_in;
   logic [15:0]            pend_task_ff, pend_task_in;
   logic [RES_W-1:0]       disp_cnt_ff, disp_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   slot_entry_type         slot_mem [TIMER_SLOTS];
   slot_entry_type         mem_rdata_ff;
   slot_entry_type         mem_wdata;
   logic [SLOT_W-1:0]      mem_raddr;
   logic [SLOT_W-1:0]      mem_waddr;
   logic                   mem_we;

   logic                   can_emit;
   logic                   req_fire;
   logic [31:0]            delay_clamped;
   logic                   free_found;
   logic [SLOT_W-1:0]      free_idx;
   logic                   scan_end;
   logic [SLOT_W:0]        eval_idx_wide;
   logic [SLOT_W-1:0]      eval_idx;
   logic [31:0]            cand_age;
   logic [31:0]            cand_sage;
   logic                   cand_ok;
   logic                   cand_wins;

   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && can_emit);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign delay_clamped = req_data.delay_ticks[31] ? DELAY_MAX : req_data.delay_ticks;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign scan_end      = (scan_cnt_ff == (SLOT_W + 1)'(TIMER_SLOTS));
   assign mem_raddr     = scan_end ? '0 : scan_cnt_ff[SLOT_W-1:0];
   assign eval_idx_wide = scan_cnt_ff - (SLOT_W + 1)'(1);
   assign eval_idx      = eval_idx_wide[SLOT_W-1:0];
   assign cand_age      = ct_ff - mem_rdata_ff.expiry;
   assign cand_sage     = ns_ff - mem_rdata_ff.seq_num;
   assign cand_ok       = (state_ff == ST_SCAN) && (scan_cnt_ff != '0) &&
                          valid_ff[eval_idx] && !cand_age[31];
   assign cand_wins     = cand_ok && (!found_ff || (cand_age > best_age_ff) ||
                          ((cand_age == best_age_ff) && (cand_sage > best_sage_ff)));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= slot_mem[mem_raddr];
   end

   always_comb begin
      state_in       = state_ff;
      ct_in          = ct_ff;
      ns_in          = ns_ff;
      valid_in       = valid_ff;
      scan_cnt_in    = scan_cnt_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      best_sage_in   = best_sage_ff;
      best_period_in = best_period_ff;
      best_task_in   = best_task_ff;
      pend_valid_in  = pend_valid_ff;
      pend_task_in   = pend_task_ff;
      disp_cnt_in    = disp_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      mem_we         = 1'b0;
      mem_waddr      = best_idx_ff;
      mem_wdata.expiry  = ct_ff + best_period_ff;
      mem_wdata.period  = best_period_ff;
      mem_wdata.task_id = best_task_ff;
      mem_wdata.seq_num = ns_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_data.req_type == REQ_ARM_ONCE ||
                            req_data.req_type == REQ_ARM_PERIODIC) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.out_handle = req_data.task_handle;
                  rsp_data_in.is_last    = 1'b1;
                  priority if (req_data.delay_ticks == '0) begin
                     rsp_data_in.result_kind = RES_DISPATCH;
                  end else if (!free_found) begin
                     rsp_data_in.result_kind = RES_DROPPED;
                  end else begin
                     rsp_data_in.result_kind = RES_ARMED;
                     mem_we            = 1'b1;
                     mem_waddr         = free_idx;
                     mem_wdata.expiry  = ct_ff + delay_clamped;
                     mem_wdata.period  = (req_data.req_type == REQ_ARM_PERIODIC) ?
                                         delay_clamped : '0;
                     mem_wdata.task_id = req_data.task_handle;
                     mem_wdata.seq_num = ns_ff;
                     valid_in[free_idx] = 1'b1;
                     ns_in             = ns_ff + 32'd1;
                  end
               end else if (req_data.req_type == REQ_TICK) begin
                  ct_in         = ct_ff + 32'd1;
                  scan_cnt_in   = '0;
                  found_in      = 1'b0;
                  pend_valid_in = 1'b0;
                  disp_cnt_in   = '0;
                  state_in      = ST_SCAN;
               end else begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.result_kind = RES_IDLE_TICK;
                  rsp_data_in.out_handle  = '0;
                  rsp_data_in.is_last     = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (cand_wins) begin
               found_in       = 1'b1;
               best_idx_in    = eval_idx;
               best_age_in    = cand_age;
               best_sage_in   = cand_sage;
               best_period_in = mem_rdata_ff.period;
               best_task_in   = mem_rdata_ff.task_id;
            end
            if (scan_end) begin
               state_in = ST_DECIDE;
            end else begin
               scan_cnt_in = scan_cnt_ff + (SLOT_W + 1)'(1);
            end
         end
         ST_DECIDE: begin
            if (can_emit) begin
               if (found_ff) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.result_kind = RES_DISPATCH;
                     rsp_data_in.out_handle  = pend_task_ff;
                     rsp_data_in.is_last     = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_task_in  = best_task_ff;
                  disp_cnt_in   = disp_cnt_ff + RES_W'(1);
                  if (best_period_ff != '0) begin
                     mem_we = 1'b1;
                     ns_in  = ns_ff + 32'd1;
                  end else begin
                     valid_in[best_idx_ff] = 1'b0;
                  end
                  if (disp_cnt_ff == RES_W'(MAX_RESULTS - 1)) begin
                     state_in = ST_FLUSH;
                  end else begin
                     state_in    = ST_SCAN;
                     scan_cnt_in = '0;
                     found_in    = 1'b0;
                  end
               end else begin
                  rsp_valid_in        = 1'b1;
                  rsp_data_in.is_last = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_data_in.result_kind = RES_DISPATCH;
                     rsp_data_in.out_handle  = pend_task_ff;
                  end else begin
                     rsp_data_in.result_kind = RES_IDLE_TICK;
                     rsp_data_in.out_handle  = '0;
                  end
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (can_emit) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_kind = RES_DISPATCH;
               rsp_data_in.out_handle  = pend_task_ff;
               rsp_data_in.is_last     = 1'b1;
               pend_valid_in           = 1'b0;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ct_ff         <= '0;
         ns_ff         <= '0;
         valid_ff      <= '0;
         scan_cnt_ff   <= '0;
         found_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         disp_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ct_ff         <= ct_in;
         ns_ff         <= ns_in;
         valid_ff      <= valid_in;
         scan_cnt_ff   <= scan_cnt_in;
         found_ff      <= found_in;
         pend_valid_ff <= pend_valid_in;
         disp_cnt_ff   <= disp_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      best_sage_ff   <= best_sage_in;
      best_period_ff <= best_period_in;
      best_task_ff   <= best_task_in;
      pend_task_ff   <= pend_task_in;
      rsp_data_ff    <= rsp_data_in;
   end

   `ASSERT_IMPLIES(a_write_state, clock, reset, mem_we,
                   state_ff == ST_IDLE || state_ff == ST_DECIDE,
                   "slot write outside arm or write-back")
   `ASSERT_IMPLIES(a_time_held, clock, reset,
                   state_ff == ST_SCAN && $past(state_ff) == ST_SCAN, $stable(ct_ff),
                   "time changed during scan")
   `ASSERT_IMPLIES(a_best_live, clock, reset, state_ff == ST_DECIDE && found_ff,
                   valid_ff[best_idx_ff], "selected slot not armed")
   `ASSERT_ALWAYS(a_dispatch_bound, clock, reset, disp_cnt_ff <= RES_W'(MAX_RESULTS),
                  "dispatch count over limit")
   `ASSERT_IMPLIES(a_idle_no_pending, clock, reset, state_ff == ST_IDLE, !pend_valid_ff,
                   "dispatch left pending in idle")

endmodule

FILE: test/periodic_timer_scheduler_tb.sv
// Self-checking testbench for the periodic timer scheduler with a timer-table predictor.
module periodic_timer_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pts_pkg::*;

   localparam logic [1:0]  REQ_UNUSED   = 2'd3;
   localparam logic [31:0] HALF_RANGE   = 32'h8000_0000;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = (MAX_RESULTS + 1) * (TIMER_SLOTS + 2) + 20;
   localparam int          HOLDOFF_AT   = 150;
   localparam int          HOLDOFF_LEN  = 800;
   localparam int          RANDOM_ITEMS = 457;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   req_payload_type pending_requests[$];
   rsp_payload_type due_results[$];

   int accepted_requests = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int burst_left = 1;
   int stall_left = 0;
   int holdoff_left = 0;
   bit holdoff_done = 1'b0;

   logic [31:0] now_ticks;
   logic [31:0] arm_count;
   logic        slot_used[TIMER_SLOTS];
   logic [31:0] slot_due[TIMER_SLOTS];
   logic [31:0] slot_interval[TIMER_SLOTS];
   logic [15:0] slot_owner[TIMER_SLOTS];
   logic [31:0] slot_order[TIMER_SLOTS];

   periodic_timer_scheduler uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] age_of_slot(int s);
      return now_ticks - slot_due[s];
   endfunction

   function automatic void expect_result(logic [1:0] kind, logic [15:0] handle, logic last);
      rsp_payload_type r;
      r.result_kind = kind;
      r.out_handle  = handle;
      r.is_last     = last;
      due_results.push_back(r);
   endfunction

   task automatic step_timer_table(input req_payload_type rq);
      int              free_idx;
      int              pick;
      int              dispatched;
      logic [31:0]     delay;
      rsp_payload_type r;
      delay = rq.delay_ticks;
      case (rq.req_type)
         REQ_ARM_ONCE, REQ_ARM_PERIODIC: begin
            if (delay == 32'd0) begin
               expect_result(RES_DISPATCH, rq.task_handle, 1'b1);
            end else begin
               if (delay > DELAY_MAX) delay = DELAY_MAX;
               free_idx = -1;
               for (int s = 0; s < TIMER_SLOTS; s++) begin
                  if (!slot_used[s]) begin
                     free_idx = s;
                     break;
                  end
               end
               if (free_idx < 0) begin
                  expect_result(RES_DROPPED, rq.task_handle, 1'b1);
               end else begin
                  slot_used[free_idx]     = 1'b1;
                  slot_due[free_idx]      = now_ticks + delay;
                  slot_interval[free_idx] = (rq.req_type == REQ_ARM_PERIODIC) ? delay : 32'd0;
                  slot_owner[free_idx]    = rq.task_handle;
                  slot_order[free_idx]    = arm_count;
                  arm_count               = arm_count + 32'd1;
                  expect_result(RES_ARMED, rq.task_handle, 1'b1);
               end
            end
         end
         REQ_TICK: begin
            now_ticks  = now_ticks + 32'd1;
            dispatched = 0;
            while (dispatched < MAX_RESULTS) begin
               pick = -1;
               for (int s = 0; s < TIMER_SLOTS; s++) begin
                  if (slot_used[s] && age_of_slot(s) < HALF_RANGE) begin
                     if (pick < 0) begin
                        pick = s;
                     end else if (age_of_slot(s) != age_of_slot(pick)) begin
                        if (age_of_slot(s) > age_of_slot(pick)) pick = s;
                     end else if ((arm_count - slot_order[s]) >
                                  (arm_count - slot_order[pick])) begin
                        pick = s;
                     end
                  end
               end
               if (pick < 0) break;
               expect_result(RES_DISPATCH, slot_owner[pick], 1'b0);
               dispatched++;
               if (slot_interval[pick] != 32'd0) begin
                  slot_due[pick]   = now_ticks + slot_interval[pick];
                  slot_order[pick] = arm_count;
                  arm_count        = arm_count + 32'd1;
               end else begin
                  slot_used[pick] = 1'b0;
               end
            end
            if (dispatched == 0) begin
               expect_result(RES_IDLE_TICK, 16'h0000, 1'b1);
            end else begin
               r = due_results.pop_back();
               r.is_last = 1'b1;
               due_results.push_back(r);
            end
         end
         default: begin
            expect_result(RES_IDLE_TICK, 16'h0000, 1'b1);
         end
      endcase
   endtask

   function automatic void queue_request(logic [1:0] kind, logic [15:0] handle,
                                         logic [31:0] delay);
      req_payload_type rq;
      rq.req_type    = kind;
      rq.task_handle = handle;
      rq.delay_ticks = delay;
      pending_requests.push_back(rq);
   endfunction

   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_valid  <= 1'b0;
         gap_left   <= 0;
         burst_left <= 1;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            step_timer_table(req_data);
            accepted_requests <= accepted_requests + 1;
         end
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_requests.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_requests.pop_front();
            if (burst_left <= 1) begin
               burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : drive_stall
      int pattern;
      if (reset) begin
         rsp_stall    <= 1'b0;
         stall_left   <= 0;
         holdoff_left <= 0;
      end else if (holdoff_left > 0) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && accepted_requests >= HOLDOFF_AT) begin
         rsp_stall    <= 1'b1;
         holdoff_left <= HOLDOFF_LEN;
         holdoff_done <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         pattern = $urandom_range(0, 9);
         if (pattern < 2) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(20, 60);
         end else if (pattern < 6) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
         end else begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 8);
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_results.size() == 0) begin
            $error("unexpected transaction: result_kind %0d out_handle %h is_last %0b",
                   rsp_data.result_kind, rsp_data.out_handle, rsp_data.is_last);
            mismatches++;
         end else begin
            want = due_results.pop_front();
            if (rsp_data.result_kind !== want.result_kind) begin
               $error("result_kind expected %0d actual %0d",
                      want.result_kind, rsp_data.result_kind);
               mismatches++;
            end
            if (rsp_data.out_handle !== want.out_handle) begin
               $error("out_handle expected %h actual %h", want.out_handle, rsp_data.out_handle);
               mismatches++;
            end
            if (rsp_data.is_last !== want.is_last) begin
               $error("is_last expected %0b actual %0b", want.is_last, rsp_data.is_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_timer_scheduler verification failed");
         $finish;
      end
   end

   initial begin : run_test
      int          roll;
      int          periodic_left;
      int          long_left;
      logic [31:0] delay;
      now_ticks     = '0;
      arm_count     = '0;
      periodic_left = 3;
      long_left     = 2;
      for (int s = 0; s < TIMER_SLOTS; s++) begin
         slot_used[s]     = 1'b0;
         slot_due[s]      = '0;
         slot_interval[s] = '0;
         slot_owner[s]    = '0;
         slot_order[s]    = '0;
      end

      queue_request(REQ_ARM_ONCE, 16'h0000, 32'd0);
      queue_request(REQ_ARM_PERIODIC, 16'hFFFF, 32'd0);
      queue_request(REQ_TICK, 16'h1234, 32'hFFFF_FFFF);
      queue_request(REQ_UNUSED, 16'hFFFF, 32'hFFFF_FFFF);
      queue_request(REQ_ARM_ONCE, 16'hFFFF, 32'hFFFF_FFFF);
      queue_request(REQ_ARM_PERIODIC, 16'h8000, 32'h8000_0000);
      queue_request(REQ_ARM_PERIODIC, 16'h0001, 32'd1);
      for (int i = 0; i < 11; i++) queue_request(REQ_ARM_ONCE, 16'h0100 + 16'(i), 32'd1);
      queue_request(REQ_ARM_ONCE, 16'h5555, 32'd3);
      queue_request(REQ_ARM_ONCE, 16'hAAAA, 32'd2);
      queue_request(REQ_ARM_ONCE, 16'hABCD, 32'd5);
      queue_request(REQ_TICK, 16'h0000, 32'd0);
      queue_request(REQ_TICK, 16'hFFFF, 32'h0000_0001);
      queue_request(REQ_TICK, 16'h00FF, 32'h7FFF_FFFF);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            queue_request(REQ_TICK, 16'($urandom), $urandom);
         end else if (roll < 42) begin
            queue_request(REQ_UNUSED, 16'($urandom), $urandom);
         end else if (roll < 46) begin
            queue_request(2'($urandom_range(0, 1)), 16'($urandom), 32'd0);
         end else if (roll < 49 && periodic_left > 0) begin
            periodic_left--;
            queue_request(REQ_ARM_PERIODIC, 16'($urandom), $urandom_range(1, 6));
         end else if (roll < 51 && long_left > 0) begin
            long_left--;
            delay = $urandom | 32'h0010_0000;
            queue_request(2'($urandom_range(0, 1)), 16'($urandom), delay);
         end else if (roll < 58) begin
            queue_request(REQ_ARM_ONCE, 16'($urandom), $urandom_range(13, 60));
         end else begin
            queue_request(REQ_ARM_ONCE, 16'($urandom), $urandom_range(1, 12));
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("periodic_timer_scheduler verification clean");
      end else begin
         $display("periodic_timer_scheduler verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/pts_pkg.sv
src/periodic_timer_scheduler.sv
test/periodic_timer_scheduler_tb.sv
